>>> design/rtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtf_pkg: shared types and constants
// Command codes, event codes, realtime matcher types and reset values for the
// serial receive filter.
// ----------------------------------------------------------------------------
package rtf_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 8;
  localparam int CFG_CNT   = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           cmd_t;

  // command codes carried by a transaction
  localparam cmd_t CMD_RX    = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_FLUSH = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t CFG_STATUS = 2'd0;
  localparam cfg_idx_t CFG_START  = 2'd1;
  localparam cfg_idx_t CFG_HOLD   = 2'd2;
  localparam cfg_idx_t CFG_RESET  = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STORED  = 3'd1,
    EV_DROPPED = 3'd2,
    EV_STATUS  = 3'd3,
    EV_START   = 3'd4,
    EV_HOLD    = 3'd5,
    EV_RESET   = 3'd6
  } ev_t;

  // realtime character reset values, in register order
  localparam byte_t RST_STATUS_CHAR = 8'd63;
  localparam byte_t RST_START_CHAR  = 8'd126;
  localparam byte_t RST_HOLD_CHAR   = 8'd33;
  localparam byte_t RST_RESET_CHAR  = 8'd24;

  // match result handed from cell to cell
  typedef struct packed {
    logic hit;
    ev_t  ev;
  } match_t;

endpackage
`default_nettype wire

>>> design/rtf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtf_if: channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface rtf_in_if;
  logic           valid;
  logic           ready;
  rtf_pkg::cmd_t  cmd;
  rtf_pkg::byte_t rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface rtf_out_if;
  logic           valid;
  logic           ready;
  rtf_pkg::ev_t   event_res;
  rtf_pkg::byte_t read_data;
  logic           read_valid;
  rtf_pkg::fill_t fill_level;

  modport source (output valid, output event_res, output read_data,
                  output read_valid, output fill_level, input ready);
  modport sink   (input valid, input event_res, input read_data,
                  input read_valid, input fill_level, output ready);
endinterface
`default_nettype wire

>>> design/rtf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> design/rtf_match_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtf_match_cell: one realtime character matcher
// Holds one configured character; passes an upstream hit through, otherwise
// reports its own event when the byte matches.
// ----------------------------------------------------------------------------
module rtf_match_cell #(
  parameter rtf_pkg::cfg_idx_t CELL_IDX = '0,
  parameter rtf_pkg::byte_t    RST_CHAR = '0,
  parameter rtf_pkg::ev_t      CELL_EV  = rtf_pkg::EV_NONE
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire rtf_pkg::cfg_idx_t cfg_index,
  input  wire rtf_pkg::byte_t    cfg_data,
  input  wire rtf_pkg::byte_t    rx_byte,
  input  wire rtf_pkg::match_t   match_up,
  output      rtf_pkg::match_t   match_dn
);
  import rtf_pkg::*;

  byte_t char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r <= RST_CHAR;
    end else if (cfg_we && (cfg_index == CELL_IDX)) begin
      char_r <= cfg_data;
    end
  end

  // earlier cell wins on equal characters
  always_comb begin
    if (match_up.hit) begin
      match_dn = match_up;
    end else if (rx_byte == char_r) begin
      match_dn = '{hit: 1'b1, ev: CELL_EV};
    end else begin
      match_dn = '{hit: 1'b0, ev: EV_NONE};
    end
  end

endmodule
`default_nettype wire

>>> design/serial_rx_fifo_realtime_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_rx_fifo_realtime_filter: serial receive buffer with realtime filter
// Receive bytes pass a row of four matcher cells; realtime characters turn
// into events, all other bytes go into a ring buffer of DEPTH-1 entries.
// ----------------------------------------------------------------------------
// usage:
//   in_rx   : command transactions (cmd = receive byte / read / flush)
//   out_res : one result transaction per command (event, popped byte,
//             read flag, fill level after the command)
//   cfg_*   : write port for the four realtime characters, write only
//             while no transaction is in flight
// timing:
//   a command is taken when the block holds no command in flight; pointers
//   update in the accept cycle, the ring buffer RAM returns read data in the
//   next cycle and the result lands in the output register after that; a
//   new command is taken only once the previous one has left the in-flight
//   stage for the output register
// stall:
//   while out_res is stalled the output register holds; one more command
//   may complete into the internal stage, then in_rx.ready stays low
// reset:
//   rst_n (synchronous) empties the buffer, restores the default realtime
//   characters and drops any transaction in flight; RAM contents are not
//   cleared, an empty buffer never reads them
// ----------------------------------------------------------------------------
module serial_rx_fifo_realtime_filter #(
  parameter int DEPTH = rtf_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rtf_in_if.sink                 in_rx,
  rtf_out_if.source              out_res,
  input  wire logic              cfg_we,
  input  wire rtf_pkg::cfg_idx_t cfg_index,
  input  wire rtf_pkg::byte_t    cfg_data
);
  import rtf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W:0]   DEPTH_V = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  typedef logic [PTR_W-1:0] ptr_t;

  // advance a pointer around the ring
  function automatic ptr_t wrap_next(input ptr_t p);
    if (p == PTR_MAX) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // ---- realtime matcher chain ----
  localparam byte_t    CELL_RST [CFG_CNT] = '{RST_STATUS_CHAR, RST_START_CHAR,
                                              RST_HOLD_CHAR, RST_RESET_CHAR};
  localparam ev_t      CELL_EVS [CFG_CNT] = '{EV_STATUS, EV_START, EV_HOLD, EV_RESET};
  localparam cfg_idx_t CELL_IDS [CFG_CNT] = '{CFG_STATUS, CFG_START, CFG_HOLD, CFG_RESET};

  match_t chain [CFG_CNT+1];

  assign chain[0] = '{hit: 1'b0, ev: EV_NONE};

  for (genvar i = 0; i < CFG_CNT; i++) begin : g_cell
    rtf_match_cell #(
      .CELL_IDX (CELL_IDS[i]),
      .RST_CHAR (CELL_RST[i]),
      .CELL_EV  (CELL_EVS[i])
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .rx_byte   (in_rx.rx_byte),
      .match_up  (chain[i]),
      .match_dn  (chain[i+1])
    );
  end

  // ---- pointers and command decode ----
  ptr_t  wp_r, wp_nxt;
  ptr_t  rp_r, rp_nxt;
  logic  busy_r, busy_nxt;
  ev_t   st_ev_r, st_ev_nxt;
  logic  st_rvalid_r, st_rvalid_nxt;
  fill_t st_fill_r, st_fill_nxt;

  logic  accept;
  logic  move;
  logic  ram_we;
  logic  ram_re;
  byte_t ram_rd_data;
  ptr_t  wp_inc;
  logic [PTR_W:0] lvl;

  assign accept = in_rx.valid && in_rx.ready;
  assign wp_inc = wrap_next(wp_r);

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    st_ev_nxt     = EV_NONE;
    st_rvalid_nxt = 1'b0;
    if (accept) begin
      unique case (in_rx.cmd)
        CMD_RX: begin
          if (chain[CFG_CNT].hit) begin
            st_ev_nxt = chain[CFG_CNT].ev;
            if (chain[CFG_CNT].ev == EV_RESET) begin
              wp_nxt = '0;
              rp_nxt = '0;
            end
          end else if (wp_inc != rp_r) begin
            ram_we    = 1'b1;
            wp_nxt    = wp_inc;
            st_ev_nxt = EV_STORED;
          end else begin
            st_ev_nxt = EV_DROPPED;
          end
        end
        CMD_READ: begin
          if (wp_r != rp_r) begin
            ram_re        = 1'b1;
            st_rvalid_nxt = 1'b1;
            rp_nxt        = wrap_next(rp_r);
          end
        end
        CMD_FLUSH: begin
          rp_nxt = wp_r;
        end
        default: begin
          // unused code: no effect
        end
      endcase
    end
  end

  // fill level after this command
  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      lvl = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      lvl = {1'b0, wp_nxt} + DEPTH_V - {1'b0, rp_nxt};
    end
    st_fill_nxt = FILL_W'(lvl);
  end

  // ---- ring buffer storage ----
  rtf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (in_rx.rx_byte),
    .rd_en   (ram_re),
    .rd_addr (rp_r),
    .rd_data (ram_rd_data)
  );

  // ---- in-flight stage and output register ----
  logic  out_valid_r, out_valid_nxt;
  ev_t   out_ev_r;
  byte_t out_data_r;
  logic  out_rvalid_r;
  fill_t out_fill_r;

  // stage moves to the output register once that slot frees up
  assign move = busy_r && (!out_valid_r || out_res.ready);

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      st_ev_r     <= st_ev_nxt;
      st_rvalid_r <= st_rvalid_nxt;
      st_fill_r   <= st_fill_nxt;
    end
    if (move) begin
      out_ev_r     <= st_ev_r;
      out_data_r   <= st_rvalid_r ? ram_rd_data : '0;
      out_rvalid_r <= st_rvalid_r;
      out_fill_r   <= st_fill_r;
    end
  end

  // ---- channel hookup ----
  assign in_rx.ready        = !busy_r;
  assign out_res.valid      = out_valid_r;
  assign out_res.event_res  = out_ev_r;
  assign out_res.read_data  = out_data_r;
  assign out_res.read_valid = out_rvalid_r;
  assign out_res.fill_level = out_fill_r;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: serial receive filter with ring buffer
// Drives command transactions in bursts against a stalling result sink. A
// short table of directed commands opens the run, then random phases follow,
// each under its own set of realtime characters. Every result transaction is
// checked field by field against an in-order queue filled by a predictor of
// the ring buffer and the realtime matcher, or by the table for typed rows.
// ----------------------------------------------------------------------------
module testbench;
  import rtf_pkg::*;

  localparam int   RING_DEPTH = DEPTH_DEF;
  localparam int   N_DIRECTED = 20;
  // command code with no function, the block must ignore it
  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    ev_t   ev;
    byte_t data;
    logic  rvalid;
    fill_t fill;
  } rx_result_t;

  typedef struct packed {
    cmd_t       cmd;
    byte_t      rx;
    logic       typed;
    rx_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  byte_t cfg_data;

  rtf_in_if  in_rx ();
  rtf_out_if out_res ();

  serial_rx_fifo_realtime_filter #(.DEPTH(RING_DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_rx     (in_rx),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: realtime characters and ring buffer
  byte_t       rt_chars [CFG_CNT] = '{RST_STATUS_CHAR, RST_START_CHAR,
                                      RST_HOLD_CHAR, RST_RESET_CHAR};
  byte_t       ring [RING_DEPTH];
  int unsigned wr_idx = 0;
  int unsigned rd_idx = 0;

  rx_result_t  pending_results [$];
  int          errors = 0;

  // typed expectation travelling with the transaction on the input channel
  logic        drv_typed = 1'b0;
  rx_result_t  drv_expect = '0;
  int          burst_left = 0;

  // directed commands; typed rows carry the result read off by hand
  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty buffer: read, flush and the unused code all report nothing
    '{CMD_READ,   8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd0}},
    '{CMD_FLUSH,  8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd0}},
    '{CMD_UNUSED, 8'hFF, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd0}},
    // default realtime characters
    '{CMD_RX,     8'd63, 1'b1, '{EV_STATUS,  8'h00, 1'b0, 8'd0}},
    '{CMD_RX,     8'd126, 1'b1, '{EV_START,  8'h00, 1'b0, 8'd0}},
    '{CMD_RX,     8'd33, 1'b1, '{EV_HOLD,    8'h00, 1'b0, 8'd0}},
    '{CMD_RX,     8'd24, 1'b1, '{EV_RESET,   8'h00, 1'b0, 8'd0}},
    // byte extremes go into the buffer
    '{CMD_RX,     8'h00, 1'b1, '{EV_STORED,  8'h00, 1'b0, 8'd1}},
    '{CMD_RX,     8'hFF, 1'b1, '{EV_STORED,  8'h00, 1'b0, 8'd2}},
    '{CMD_RX,     8'h55, 1'b1, '{EV_STORED,  8'h00, 1'b0, 8'd3}},
    '{CMD_READ,   8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b1, 8'd2}},
    '{CMD_READ,   8'h00, 1'b1, '{EV_NONE,    8'hFF, 1'b1, 8'd1}},
    // unused code keeps the fill level
    '{CMD_UNUSED, 8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd1}},
    // reset character clears a non-empty buffer
    '{CMD_RX,     8'd24, 1'b1, '{EV_RESET,   8'h00, 1'b0, 8'd0}},
    '{CMD_READ,   8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd0}},
    '{CMD_RX,     8'hAA, 1'b0, '0},
    '{CMD_RX,     8'h01, 1'b0, '0},
    '{CMD_READ,   8'h00, 1'b0, '0},
    // flush drops what is left
    '{CMD_FLUSH,  8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd0}},
    '{CMD_READ,   8'h00, 1'b1, '{EV_NONE,    8'h00, 1'b0, 8'd0}}
  };

  // next result of the block for one command, advances the predictor state
  function automatic rx_result_t predict_command(input cmd_t c, input byte_t b);
    rx_result_t  r;
    int unsigned nxt;
    r = '{EV_NONE, 8'h00, 1'b0, 8'd0};
    case (c)
      CMD_RX: begin
        // first match wins in register order
        if (b == rt_chars[CFG_STATUS]) begin
          r.ev = EV_STATUS;
        end else if (b == rt_chars[CFG_START]) begin
          r.ev = EV_START;
        end else if (b == rt_chars[CFG_HOLD]) begin
          r.ev = EV_HOLD;
        end else if (b == rt_chars[CFG_RESET]) begin
          r.ev = EV_RESET;
          wr_idx = 0;
          rd_idx = 0;
        end else begin
          nxt = (wr_idx + 1) % RING_DEPTH;
          if (nxt != rd_idx) begin
            ring[wr_idx] = b;
            wr_idx = nxt;
            r.ev = EV_STORED;
          end else begin
            r.ev = EV_DROPPED;
          end
        end
      end
      CMD_READ: begin
        if (wr_idx != rd_idx) begin
          r.data = ring[rd_idx];
          r.rvalid = 1'b1;
          rd_idx = (rd_idx + 1) % RING_DEPTH;
        end
      end
      CMD_FLUSH: rd_idx = wr_idx;
      default: ;
    endcase
    r.fill = fill_t'((wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // scoreboard: accepted commands push, accepted results pop and compare
  always @(posedge clk) begin : scoreboard
    rx_result_t predicted;
    rx_result_t expected;
    if (rst_n) begin
      if (in_rx.valid && in_rx.ready) begin
        predicted = predict_command(in_rx.cmd, in_rx.rx_byte);
        pending_results.push_back(drv_typed ? drv_expect : predicted);
      end
      if (out_res.valid && out_res.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with no command waiting, actual ev %0d",
                   $time, out_res.event_res);
          errors++;
        end else begin
          expected = pending_results.pop_front();
          check_field("event_res",  8'(expected.ev),     8'(out_res.event_res));
          check_field("read_data",  expected.data,       out_res.read_data);
          check_field("read_valid", 8'(expected.rvalid), 8'(out_res.read_valid));
          check_field("fill_level", expected.fill,       out_res.fill_level);
        end
      end
    end
  end

  // result sink: stall pattern switches between modes in stretches
  initial begin : result_sink
    int mode;
    int left;
    out_res.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_res.ready = 1'b1;                        // no stall
        1: out_res.ready = ($urandom_range(0, 9) >= 3);
        2: out_res.ready = (left % 3 == 0);            // periodic
        default: out_res.ready = ($urandom_range(0, 9) == 0);  // heavy stall
      endcase
    end
  end

  // one command transaction; called and left at a falling edge
  task automatic send_command(input cmd_t c, input byte_t b, input logic typed,
                              input rx_result_t res);
    if (burst_left == 0) begin
      in_rx.valid = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    in_rx.valid   = 1'b1;
    in_rx.cmd     = c;
    in_rx.rx_byte = b;
    drv_typed     = typed;
    drv_expect    = res;
    @(posedge clk);
    while (!in_rx.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  // stop sending and let every result come back before touching registers
  task automatic wait_drained;
    in_rx.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_char(input cfg_idx_t idx, input byte_t val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    rt_chars[idx] = val;
  endtask

  // random command; fill mode mostly receives and never flushes, drain mode mostly reads
  task automatic random_command(input bit fill_mode, output cmd_t c, output byte_t b);
    int p;
    int q;
    p = $urandom_range(0, 99);
    if (fill_mode) begin
      c = (p < 88) ? CMD_RX : (p < 97) ? CMD_READ : CMD_UNUSED;
    end else begin
      c = (p < 25) ? CMD_RX : (p < 85) ? CMD_READ : (p < 92) ? CMD_FLUSH : CMD_UNUSED;
    end
    // realtime characters on purpose, reset only sent on purpose while draining
    q = $urandom_range(0, 99);
    if (q < 4)       b = rt_chars[CFG_STATUS];
    else if (q < 7)  b = rt_chars[CFG_START];
    else if (q < 10) b = rt_chars[CFG_HOLD];
    else if (!fill_mode && q < 14) b = rt_chars[CFG_RESET];
    else             b = byte_t'($urandom_range(0, 255));
  endtask

  initial begin : stimulus
    byte_t sel [CFG_CNT];
    cmd_t  c;
    byte_t b;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_STATUS;
    cfg_data      = 8'h00;
    in_rx.valid   = 1'b0;
    in_rx.cmd     = CMD_RX;
    in_rx.rx_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table under the reset characters
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_command(directed_rows[i].cmd, directed_rows[i].rx,
                   directed_rows[i].typed, directed_rows[i].res);
    end

    // random phases, each with its own realtime characters
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        // extremes, all distinct
        0: sel = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        // all equal: status wins
        1: sel = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        // pairs equal: status over start, hold over reset
        2: sel = '{8'h00, 8'h00, 8'h5A, 8'h5A};
        default: begin
          for (int k = 0; k < CFG_CNT; k++) sel[k] = byte_t'($urandom_range(0, 255));
        end
      endcase
      for (int k = 0; k < CFG_CNT; k++) write_char(cfg_idx_t'(k), sel[k]);
      // fill long enough to hit the full buffer, then drain
      for (int i = 0; i < 200; i++) begin
        random_command(1'b1, c, b);
        send_command(c, b, 1'b0, '0);
      end
      for (int i = 0; i < 50; i++) begin
        random_command(1'b0, c, b);
        send_command(c, b, 1'b0, '0);
      end
    end

    in_rx.valid = 1'b0;
    drv_typed   = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
